### src/pmq_pkg.sv
`timescale 1ns / 1ps
// Package for the pose matrix to position and quaternion core.
// Holds the pipeline stage record and the fixed stage layout; no dependencies.
package pmq_pkg;

  // Stage layout: input register, products, isqrt steps, divider steps, output.
  localparam int unsigned SQRT_FIRST = 2;
  localparam int unsigned SQRT_STEPS = 16;
  localparam int unsigned DIV_PREP   = SQRT_FIRST + SQRT_STEPS;
  localparam int unsigned DIV_FIRST  = DIV_PREP + 1;
  localparam int unsigned DIV_STEPS  = 16;
  localparam int unsigned LAST_STAGE = DIV_FIRST + DIV_STEPS;
  localparam int unsigned NUM_STAGES = LAST_STAGE + 1;

  // Branch codes of the trace method.
  localparam logic [1:0] BR_TRACE = 2'd0;
  localparam logic [1:0] BR_XMAX  = 2'd1;
  localparam logic [1:0] BR_YMAX  = 2'd2;
  localparam logic [1:0] BR_ZMAX  = 2'd3;

  localparam logic signed [18:0] Q14_ONE = 19'sd16384;

  typedef struct packed {
    logic [8:0][15:0] m;      // rotation e0,e1,e2,e4,e5,e6,e8,e9,e10
    logic [2:0][31:0] tv;     // translation e12,e13,e14
    logic [8:0][47:0] prod;   // row times translation products
    logic [2:0][63:0] acc;    // row sums, then scaled position
    logic [2:0][31:0] pos;    // saturated position
    logic [1:0]       branch;
    logic             bad;
    logic [2:0][17:0] num;    // divider numerators, signed
    logic [31:0]      rem;    // isqrt remainder
    logic [31:0]      root;   // isqrt partial root
    logic [16:0]      dvs;    // divisor 2*S
    logic [15:0]      half;   // (S+1)>>1
    logic [2:0][30:0] drem;   // divider remainders
    logic [2:0][15:0] quo;    // divider quotients
    logic [2:0]       ovf;    // quotient beyond 16 bits
    logic [3:0][15:0] quat;   // w,x,y,z
  } pipe_t;

endpackage

### src/pmq_if.sv
`timescale 1ns / 1ps
// Stream interfaces for pose beats in and result beats out.
// Stand-alone; used by the pose matrix to position and quaternion core.
interface pmq_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] e0, e1, e2, e4, e5, e6, e8, e9, e10;
  logic signed [31:0] e12, e13, e14;
  modport source (output valid, e0, e1, e2, e4, e5, e6, e8, e9, e10, e12, e13, e14,
                  input ready);
  modport sink (input valid, e0, e1, e2, e4, e5, e6, e8, e9, e10, e12, e13, e14,
                output ready);
endinterface

interface pmq_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x, pos_y, pos_z;
  logic signed [15:0] quat_w, quat_x, quat_y, quat_z;
  logic               bad_input;
  modport source (output valid, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z,
                  bad_input, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z,
                bad_input, output ready);
endinterface

### src/pose_matrix_to_position_quaternion_core.sv
`timescale 1ns / 1ps
// Pose matrix to listener position and orientation quaternion, top level.
// Depends on pmq_pkg and the pmq_in_if / pmq_out_if interfaces.
//
// Usage:
//   pose   : sink channel, one beat carries rotation e0..e10 (Q2.14) and
//            translation e12..e14 (Q16.16) of an inverted pose matrix.
//   result : source channel, one beat per pose beat: position (Q16.16,
//            saturated), quaternion (Q2.14, saturated) and bad_input.
//   cfg_we / cfg_wdata : write the scene scale (unsigned Q8.16); write it
//            only while no beat is in flight.
// Throughput: one beat per cycle unless result stalls. The pipeline
//   has 36 register stages: input register, products, 16 square root
//   steps with row sums, rounding and scaling beside them, divider
//   setup, 16 restoring divider steps (one per stage), output stage.
// Reset: all stage valid bits clear, scale returns to 1.0.
// Stall: when result is valid and not ready, every stage holds and pose
//   ready drops; nothing is lost or repeated.
module pose_matrix_to_position_quaternion_core
  import pmq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [23:0] cfg_wdata,
  pmq_in_if.sink      pose,
  pmq_out_if.source   result
);

  pipe_t                 pipe [NUM_STAGES];
  pipe_t                 in_beat;
  logic [NUM_STAGES-1:0] vld;
  logic [23:0]           scale;
  logic                  en;

  // Format one quotient with sign and saturation.
  function automatic logic [15:0] fmt_q(input logic [15:0] q, input logic ovf,
                                        input logic neg);
    logic [15:0] r;
    if (!neg) begin
      r = (ovf || q > 16'd32767) ? 16'h7FFF : q;
    end else begin
      r = (ovf || q > 16'd32768) ? 16'h8000 : 16'(-q);
    end
    return r;
  endfunction

  // Work of one stage; k is fixed per instance.
  function automatic pipe_t stage_fn(input int k, input pipe_t d, input logic [23:0] sc);
    pipe_t              o;
    logic signed [17:0] tr;
    logic signed [18:0] r;
    logic signed [15:0] a0, a1, a2, a4, a5, a6, a8, a9, a10;
    logic signed [17:0] sm;
    logic [17:0]        mag;
    logic [31:0]        bitv;
    logic [46:0]        dsh;
    logic signed [63:0] t;
    logic [15:0]        s;
    int                 b;
    o = d;
    a0 = d.m[0]; a1 = d.m[1]; a2 = d.m[2]; a4 = d.m[3]; a5 = d.m[4];
    a6 = d.m[5]; a8 = d.m[6]; a9 = d.m[7]; a10 = d.m[8];
    // products, branch choice, radicand and numerators
    if (k == 1) begin
      for (int i = 0; i < 9; i++) begin
        o.prod[i] = 48'($signed(d.m[i]) * $signed(d.tv[i % 3]));
      end
      tr = 18'(a0) + 18'(a5) + 18'(a10);
      if (tr > 0) begin
        o.branch = BR_TRACE;
        r = Q14_ONE + 19'(tr);
        o.num[0] = 18'(a6) - 18'(a9);
        o.num[1] = 18'(a8) - 18'(a2);
        o.num[2] = 18'(a1) - 18'(a4);
      end else if (a0 > a5 && a0 > a10) begin
        o.branch = BR_XMAX;
        r = Q14_ONE + 19'(a0) - 19'(a5) - 19'(a10);
        o.num[0] = 18'(a6) - 18'(a9);
        o.num[1] = -(18'(a1) + 18'(a4));
        o.num[2] = -(18'(a8) + 18'(a2));
      end else if (a5 > a10) begin
        o.branch = BR_YMAX;
        r = Q14_ONE + 19'(a5) - 19'(a0) - 19'(a10);
        o.num[0] = 18'(a8) - 18'(a2);
        o.num[1] = -(18'(a1) + 18'(a4));
        o.num[2] = -(18'(a6) + 18'(a9));
      end else begin
        o.branch = BR_ZMAX;
        r = Q14_ONE + 19'(a10) - 19'(a0) - 19'(a5);
        o.num[0] = 18'(a1) - 18'(a4);
        o.num[1] = -(18'(a8) + 18'(a2));
        o.num[2] = -(18'(a6) + 18'(a9));
      end
      o.bad  = (r <= 0);
      o.rem  = o.bad ? 32'd0 : {r[17:0], 14'd0};
      o.root = 32'd0;
    end
    // row sums
    if (k == 2) begin
      for (int i = 0; i < 3; i++) begin
        o.acc[i] = 64'($signed(d.prod[3*i])) + 64'($signed(d.prod[3*i+1]))
                 + 64'($signed(d.prod[3*i+2]));
      end
    end
    // negate and round to Q16.16
    if (k == 3) begin
      for (int i = 0; i < 3; i++) begin
        o.acc[i] = (-$signed(d.acc[i]) + 64'sd8192) >>> 14;
      end
    end
    // apply scene scale; the rounded row fits in 36 bits
    if (k == 4) begin
      for (int i = 0; i < 3; i++) begin
        o.acc[i] = 64'($signed(d.acc[i][35:0]) * $signed({1'b0, sc}));
      end
    end
    // round and saturate position
    if (k == 5) begin
      for (int i = 0; i < 3; i++) begin
        t = ($signed(d.acc[i]) + 64'sd32768) >>> 16;
        if (t > 64'sd2147483647) begin
          o.pos[i] = 32'h7FFF_FFFF;
        end else if (t < -64'sd2147483648) begin
          o.pos[i] = 32'h8000_0000;
        end else begin
          o.pos[i] = t[31:0];
        end
      end
    end
    // one square root step
    if (k >= SQRT_FIRST && k < DIV_PREP) begin
      bitv = 32'h4000_0000 >> (2 * (k - SQRT_FIRST));
      if (d.rem >= d.root + bitv) begin
        o.rem  = d.rem - (d.root + bitv);
        o.root = (d.root >> 1) + bitv;
      end else begin
        o.root = d.root >> 1;
      end
    end
    // divider setup
    if (k == DIV_PREP) begin
      s      = d.root[15:0];
      o.half = 16'((17'(s) + 17'd1) >> 1);
      o.dvs  = {s, 1'b0};
      for (int i = 0; i < 3; i++) begin
        sm        = $signed(d.num[i]);
        mag       = sm[17] ? 18'(-sm) : 18'(sm);
        o.drem[i] = {mag[16:0], 14'd0} + 31'(s);
        o.ovf[i]  = {2'd0, o.drem[i]} >= {o.dvs, 16'd0};
        o.quo[i]  = 16'd0;
      end
    end
    // one restoring divider step per lane
    if (k >= DIV_FIRST && k < LAST_STAGE) begin
      b = DIV_FIRST + DIV_STEPS - 1 - k;
      for (int i = 0; i < 3; i++) begin
        dsh = {30'd0, d.dvs} << b;
        if (!d.ovf[i] && {16'd0, d.drem[i]} >= dsh) begin
          o.drem[i]  = d.drem[i] - dsh[30:0];
          o.quo[i][b] = 1'b1;
        end
      end
    end
    // place components by branch
    if (k == LAST_STAGE) begin
      o.quat = '0;
      if (!d.bad) begin
        case (d.branch)
          BR_TRACE: begin
            o.quat[0] = d.half;
            o.quat[1] = fmt_q(d.quo[0], d.ovf[0], d.num[0][17]);
            o.quat[2] = fmt_q(d.quo[1], d.ovf[1], d.num[1][17]);
            o.quat[3] = fmt_q(d.quo[2], d.ovf[2], d.num[2][17]);
          end
          BR_XMAX: begin
            o.quat[0] = fmt_q(d.quo[0], d.ovf[0], d.num[0][17]);
            o.quat[1] = d.half;
            o.quat[2] = fmt_q(d.quo[1], d.ovf[1], d.num[1][17]);
            o.quat[3] = fmt_q(d.quo[2], d.ovf[2], d.num[2][17]);
          end
          BR_YMAX: begin
            o.quat[0] = fmt_q(d.quo[0], d.ovf[0], d.num[0][17]);
            o.quat[1] = fmt_q(d.quo[1], d.ovf[1], d.num[1][17]);
            o.quat[2] = d.half;
            o.quat[3] = fmt_q(d.quo[2], d.ovf[2], d.num[2][17]);
          end
          default: begin
            o.quat[0] = fmt_q(d.quo[0], d.ovf[0], d.num[0][17]);
            o.quat[1] = fmt_q(d.quo[1], d.ovf[1], d.num[1][17]);
            o.quat[2] = fmt_q(d.quo[2], d.ovf[2], d.num[2][17]);
            o.quat[3] = d.half;
          end
        endcase
      end
    end
    return o;
  endfunction

  // Advance the whole pipe unless the output beat is stuck.
  assign en         = !vld[LAST_STAGE] || result.ready;
  assign pose.ready = en;

  // Hold the scene scale.
  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= 24'd65536;
    end else if (cfg_we) begin
      scale <= cfg_wdata;
    end
  end

  // Advance valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NUM_STAGES-2:0], pose.valid};
    end
  end

  // Pack the input beat.
  always_comb begin
    in_beat    = '0;
    in_beat.m  = {pose.e10, pose.e9, pose.e8, pose.e6, pose.e5, pose.e4,
                  pose.e2, pose.e1, pose.e0};
    in_beat.tv = {pose.e14, pose.e13, pose.e12};
  end

  // Capture the input beat.
  always_ff @(posedge clk) begin
    if (en) begin
      pipe[0] <= in_beat;
    end
  end

  // Stage registers.
  for (genvar k = 1; k < NUM_STAGES; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        pipe[k] <= stage_fn(k, pipe[k-1], scale);
      end
    end
  end

  // Drive the result beat from the last stage.
  assign result.valid     = vld[LAST_STAGE];
  assign result.pos_x     = pipe[LAST_STAGE].pos[0];
  assign result.pos_y     = pipe[LAST_STAGE].pos[1];
  assign result.pos_z     = pipe[LAST_STAGE].pos[2];
  assign result.quat_w    = pipe[LAST_STAGE].quat[0];
  assign result.quat_x    = pipe[LAST_STAGE].quat[1];
  assign result.quat_y    = pipe[LAST_STAGE].quat[2];
  assign result.quat_z    = pipe[LAST_STAGE].quat[3];
  assign result.bad_input = pipe[LAST_STAGE].bad;

  // A flagged beat carries a zero quaternion.
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.bad_input) |->
      (result.quat_w == 0 && result.quat_x == 0 && result.quat_y == 0 && result.quat_z == 0))
    else $error("bad beat with nonzero quaternion");

  // A stalled output freezes every valid bit in the pipe.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (vld[LAST_STAGE] && !result.ready) |=> $stable(vld))
    else $error("pipe moved under stall");

  // A good radicand gives a root of at least sqrt(2^14).
  a_root_min: assert property (@(posedge clk) disable iff (rst)
    (vld[DIV_PREP-1] && !pipe[DIV_PREP-1].bad) |-> (pipe[DIV_PREP-1].root >= 32'd128))
    else $error("square root below minimum");

  // A good beat never divides by zero.
  a_dvs_nonzero: assert property (@(posedge clk) disable iff (rst)
    (vld[DIV_FIRST] && !pipe[DIV_FIRST].bad) |-> (pipe[DIV_FIRST].dvs != 0))
    else $error("zero divisor");

endmodule

### bench/pmq_checker.sv
`timescale 1ns / 1ps
// Checker for the pose matrix to position and quaternion core.
// Watches the pose and result channels, predicts each result and compares; uses pmq_if.
module pmq_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [23:0] cfg_wdata,
  pmq_in_if.sink      pose_mon,
  pmq_out_if.sink     result_mon,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic signed [31:0] px, py, pz;
    logic signed [15:0] qw, qx, qy, qz;
    logic               bad;
  } pose_result_t;

  pose_result_t expected_q[$];
  logic [23:0]  scale;

  assign pending = expected_q.size();

  // Round a row sum to Q16.16, apply scale, saturate.
  function automatic logic signed [31:0] row_pos(longint a, longint b, longint c,
                                                 longint tx, longint ty, longint tz,
                                                 logic [23:0] sc);
    longint s, t, p;
    s = a * tx + b * ty + c * tz;
    t = (-s + 64'sd8192) >>> 14;
    p = (t * longint'({1'b0, sc}) + 64'sd32768) >>> 16;
    if (p > 64'sd2147483647) p = 64'sd2147483647;
    if (p < -64'sd2147483648) p = -64'sd2147483648;
    return p[31:0];
  endfunction

  // Divide a Q2.14 numerator by 2*S, ties away from zero, saturate.
  function automatic logic signed [15:0] quat_div(longint num, longint s);
    longint mag, q;
    mag = num < 0 ? -num : num;
    q = (mag * 16384 + s) / (2 * s);
    if (num < 0) q = -q;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic longint int_sqrt(longint v);
    longint r;
    r = 0;
    for (int b = 16; b >= 0; b--)
      if ((r + (64'sd1 << b)) * (r + (64'sd1 << b)) <= v) r = r + (64'sd1 << b);
    return r;
  endfunction

  function automatic pose_result_t predict_pose(logic [23:0] sc);
    pose_result_t o;
    longint m0, m1, m2, m4, m5, m6, m8, m9, m10, tx, ty, tz, tr, r, s;
    logic [1:0] br;
    logic signed [15:0] half;
    m0 = pose_mon.e0;  m1 = pose_mon.e1;  m2 = pose_mon.e2;
    m4 = pose_mon.e4;  m5 = pose_mon.e5;  m6 = pose_mon.e6;
    m8 = pose_mon.e8;  m9 = pose_mon.e9;  m10 = pose_mon.e10;
    tx = pose_mon.e12; ty = pose_mon.e13; tz = pose_mon.e14;
    o = '0;
    o.px = row_pos(m0, m1, m2, tx, ty, tz, sc);
    o.py = row_pos(m4, m5, m6, tx, ty, tz, sc);
    o.pz = row_pos(m8, m9, m10, tx, ty, tz, sc);
    tr = m0 + m5 + m10;
    if (tr > 0) begin
      br = pmq_pkg::BR_TRACE; r = 16384 + tr;
    end else if (m0 > m5 && m0 > m10) begin
      br = pmq_pkg::BR_XMAX; r = 16384 + m0 - m5 - m10;
    end else if (m5 > m10) begin
      br = pmq_pkg::BR_YMAX; r = 16384 + m5 - m0 - m10;
    end else begin
      br = pmq_pkg::BR_ZMAX; r = 16384 + m10 - m0 - m5;
    end
    if (r <= 0) begin
      o.bad = 1'b1;
      return o;
    end
    s = int_sqrt(r * 16384);
    half = 16'((s + 1) >> 1);
    case (br)
      pmq_pkg::BR_TRACE: begin
        o.qw = half; o.qx = quat_div(m6 - m9, s);
        o.qy = quat_div(m8 - m2, s); o.qz = quat_div(m1 - m4, s);
      end
      pmq_pkg::BR_XMAX: begin
        o.qw = quat_div(m6 - m9, s); o.qx = half;
        o.qy = quat_div(-(m1 + m4), s); o.qz = quat_div(-(m8 + m2), s);
      end
      pmq_pkg::BR_YMAX: begin
        o.qw = quat_div(m8 - m2, s); o.qx = quat_div(-(m1 + m4), s);
        o.qy = half; o.qz = quat_div(-(m6 + m9), s);
      end
      default: begin
        o.qw = quat_div(m1 - m4, s); o.qx = quat_div(-(m8 + m2), s);
        o.qy = quat_div(-(m6 + m9), s); o.qz = half;
      end
    endcase
    return o;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // Track scale, queue predictions, compare result beats.
  always @(posedge clk) begin
    pose_result_t g, e;
    if (rst) begin
      scale <= 24'd65536;
      fail_count = 0;
      expected_q.delete();
    end else begin
      if (cfg_we) scale <= cfg_wdata;
      if (pose_mon.valid && pose_mon.ready) expected_q.push_back(predict_pose(scale));
      if (result_mon.valid && result_mon.ready) begin
        g = '{result_mon.pos_x, result_mon.pos_y, result_mon.pos_z, result_mon.quat_w,
              result_mon.quat_x, result_mon.quat_y, result_mon.quat_z, result_mon.bad_input};
        if (expected_q.size() == 0) begin
          report("unexpected beat", 0, 0);
        end else begin
          e = expected_q.pop_front();
          if (g.px !== e.px) report("pos_x", g.px, e.px);
          if (g.py !== e.py) report("pos_y", g.py, e.py);
          if (g.pz !== e.pz) report("pos_z", g.pz, e.pz);
          if (g.qw !== e.qw) report("quat_w", g.qw, e.qw);
          if (g.qx !== e.qx) report("quat_x", g.qx, e.qx);
          if (g.qy !== e.qy) report("quat_y", g.qy, e.qy);
          if (g.qz !== e.qz) report("quat_z", g.qz, e.qz);
          if (g.bad !== e.bad) report("bad_input", g.bad, e.bad);
        end
      end
    end
  end

endmodule

### bench/pose_matrix_to_position_quaternion_core_test.sv
`timescale 1ns / 1ps
// Testbench top: drives pose beats and scale writes into the core, stalls the result side.
// Depends on pmq_pkg, pmq_if, pmq_checker and the core.
module pose_matrix_to_position_quaternion_core_test;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [23:0] cfg_wdata = '0;
  int          fail_count, pending;
  int          send_idle_pct = 0, recv_stall_pct = 0;
  int          hold_off = 0;

  pmq_in_if  pose ();
  pmq_out_if result ();

  pose_matrix_to_position_quaternion_core DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .pose(pose.sink), .result(result.source)
  );

  pmq_checker pmq_chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .pose_mon(pose.sink), .result_mon(result.sink),
    .fail_count(fail_count), .pending(pending)
  );

  always #5 clk = ~clk;

  initial begin
    pose.valid = 1'b0;
    {pose.e0, pose.e1, pose.e2, pose.e4, pose.e5, pose.e6, pose.e8, pose.e9, pose.e10} = '0;
    {pose.e12, pose.e13, pose.e14} = '0;
    result.ready = 1'b0;
  end

  // Receiver: random stalls, or a long counted hold-off.
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      result.ready <= 1'b0;
    end else begin
      result.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic [15:0] rand_rot();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(32768)) - 16384);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_tr();
    case ($urandom_range(4))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return 32'($signed($urandom_range(2000000)) - 1000000);
      default: return $urandom;
    endcase
  endfunction

  // Offer one beat and hold it until accepted; valid stays up for a back-to-back beat.
  task automatic send_pose(logic [8:0][15:0] m, logic [2:0][31:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      pose.valid <= 1'b0;
      @(posedge clk);
    end
    pose.valid <= 1'b1;
    {pose.e0, pose.e1, pose.e2, pose.e4, pose.e5, pose.e6, pose.e8, pose.e9, pose.e10} <= m;
    {pose.e12, pose.e13, pose.e14} <= t;
    do @(posedge clk); while (!pose.ready);
  endtask

  task automatic send_random();
    logic [8:0][15:0] m;
    logic [2:0][31:0] t;
    for (int k = 0; k < 9; k++) m[k] = rand_rot();
    for (int k = 0; k < 3; k++) t[k] = rand_tr();
    send_pose(m, t);
  endtask

  // Drop valid, drain, settle the pipeline, then write the scale.
  task automatic set_scale(logic [23:0] v);
    pose.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  localparam logic [15:0] ONE = 16'd16384;
  localparam logic [15:0] NEG = 16'hc000;

  initial begin
    logic [23:0] scales[5];
    scales = '{24'd65536, 24'hffffff, 24'd0, 24'd1, 24'd32768};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed: identity, each branch, small radicand, extremes.
    send_pose({ONE, 16'd0, 16'd0, 16'd0, ONE, 16'd0, 16'd0, 16'd0, ONE},
              {32'd65536, 32'hffff0000, 32'd0});
    send_pose({ONE, 16'd0, 16'd0, 16'd0, NEG, 16'd0, 16'd0, 16'd0, NEG}, '0);
    send_pose({NEG, 16'd0, 16'd0, 16'd0, ONE, 16'd0, 16'd0, 16'd0, NEG}, '0);
    send_pose({NEG, 16'd0, 16'd0, 16'd0, NEG, 16'd0, 16'd0, 16'd0, ONE}, '0);
    send_pose({16'd0, 16'd100, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}, '0);
    send_pose({16'd0, 16'h7fff, 16'h8000, 16'h7fff, 16'd0, 16'h8000, 16'h8000, 16'h7fff,
               16'd0}, {32'h7fffffff, 32'h80000000, 32'h7fffffff});
    send_pose({16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff,
               16'h7fff, 16'h8000}, {32'h80000000, 32'h80000000, 32'h80000000});
    send_pose({16'hffff, 16'h7fff, 16'h8000, 16'h8000, 16'd1, 16'h7fff, 16'h7fff,
               16'h8000, 16'd0}, '0);
    send_pose({16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
               16'h7fff, 16'h7fff}, {32'h7fffffff, 32'h7fffffff, 32'h7fffffff});
    send_pose({16'hc001, 16'd5, 16'd7, 16'hfff0, 16'hc000, 16'd3, 16'd9, 16'hfffe,
               16'hbfff}, {32'h00012345, 32'hfedcba98, 32'd1});
    for (int k = 0; k < 10; k++) send_random();
    // Random phases over scale settings and idle patterns.
    for (int ph = 0; ph < 5; ph++) begin
      set_scale(ph == 4 ? 24'($urandom) : scales[(ph + 1) % 5]);
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        3: begin send_idle_pct = 10; recv_stall_pct = 10; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; hold_off <= 200; end
      endcase
      for (int k = 0; k < 235; k++) send_random();
    end
    pose.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
